>>> design/sflc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflc_pkg
// Shared types and constants of the sync-framed LED command parser.
// ----------------------------------------------------------------------------
package sflc_pkg;

  // Frame type codes
  localparam logic [7:0] TYPE_SET    = 8'h01;
  localparam logic [7:0] TYPE_GET    = 8'h02;
  localparam logic [7:0] TYPE_STATUS = 8'h03;

  // Reply type codes
  localparam logic [7:0] REPLY_ACK     = 8'h00;
  localparam logic [7:0] REPLY_STATUS  = 8'h03;
  localparam logic [7:0] REPLY_UNKNOWN = 8'hFF;

  // Sync word after reset, first byte on the line in the top byte
  localparam logic [31:0] SYNC_WORD_RESET = 32'hAABBCCDD;

  // Decoded frame handed from the parser to the executor
  typedef struct packed {
    logic [7:0] msg_type;
    logic [7:0] led_index;
    logic [7:0] led_value;
  } frame_t;

  // One finished result beat
  typedef struct packed {
    logic [7:0] msg_type;
    logic [7:0] cmd_led_index;
    logic [7:0] cmd_led_value;
    logic [7:0] reply_type;
    logic [7:0] reply_led_index;
    logic       reply_led_state;
    logic [2:0] led_outputs;
  } result_t;

endpackage

>>> design/sync_frame_led_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_led_command_parser
// Sync-word framed byte parser that runs LED set/get commands.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle. The parser accepts a byte in every
// cycle unless its two-entry frame queue is full; a frame enters that queue
// at the edge that accepts its last byte, and the executor runs one frame per
// cycle into a two-entry result queue unless it is full. With both empty, a
// frame is registered in the frame queue and its result in the result queue,
// whose head drives the result ports until popped. Input backpressure appears
// only when both queues fill because results are not popped. The sync word
// register is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module sync_frame_led_command_parser
  import sflc_pkg::*;
#(
  parameter int NUM_LEDS = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  msg_type_o,
  output logic [7:0]  cmd_led_index_o,
  output logic [7:0]  cmd_led_value_o,
  output logic [7:0]  reply_type_o,
  output logic [7:0]  reply_led_index_o,
  output logic        reply_led_state_o,
  output logic [2:0]  led_outputs_o
);

  logic    byte_valid;
  logic    frm_push, frm_full, frm_empty, frm_pop;
  frame_t  frm_in, frm_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  assign cfg_ready_o = 1'b1;
  assign full        = frm_full;
  assign byte_valid  = push && !frm_full;

  // Parse incoming bytes into frames
  sflc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (byte_valid),
    .rx_byte_i    (rx_byte_i),
    .frame_push_o (frm_push),
    .frame_o      (frm_in)
  );

  // Hold decoded frames between parser and executor
  sflc_fifo #(
    .WIDTH ($bits(frame_t)),
    .DEPTH (2)
  ) u_frame_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frm_push),
    .data_i  (frm_in),
    .full_o  (frm_full),
    .pop_i   (frm_pop),
    .data_o  (frm_out),
    .empty_o (frm_empty)
  );

  // Execute commands against the LED bank
  sflc_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (!frm_empty),
    .frame_i       (frm_out),
    .frame_pop_o   (frm_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (res_in)
  );

  // Hold results until popped
  sflc_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign msg_type_o        = res_out.msg_type;
  assign cmd_led_index_o   = res_out.cmd_led_index;
  assign cmd_led_value_o   = res_out.cmd_led_value;
  assign reply_type_o      = res_out.reply_type;
  assign reply_led_index_o = res_out.reply_led_index;
  assign reply_led_state_o = res_out.reply_led_state;
  assign led_outputs_o     = res_out.led_outputs;

endmodule

>>> design/sflc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflc_fifo
// Small register queue with push/full and pop/empty; head is shown directly.
// ----------------------------------------------------------------------------
module sflc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers, wrapping at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> design/sflc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflc_front
// Byte parser: hunts for the sync word, collects type and parameter bytes and
// emits one decoded frame per completed frame.
// ----------------------------------------------------------------------------
module sflc_front
  import sflc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        byte_valid_i,
  input  logic [7:0]  rx_byte_i,
  output logic        frame_push_o,
  output frame_t      frame_o
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_TYPE   = 3'b010,
    PH_PARAMS = 3'b100
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] sync_q;
  logic [23:0] win_q, win_d;
  logic [1:0]  fill_q, fill_d;
  logic [7:0]  held_q, held_d;
  logic [1:0]  left_q, left_d;
  logic [15:0] params_q, params_d;
  logic [31:0] cand;
  logic [1:0]  n_type, n_held;
  logic        first;

  // Parameter bytes that follow a given type
  function automatic logic [1:0] param_count(input logic [7:0] t);
    logic [1:0] n;
    n = 2'd0;
    if (t inside {TYPE_SET, TYPE_STATUS}) begin
      n = 2'd2;
    end else if (t == TYPE_GET) begin
      n = 2'd1;
    end
    return n;
  endfunction

  assign cand   = {win_q, rx_byte_i};
  assign n_type = param_count(rx_byte_i);
  assign n_held = param_count(held_q);
  assign first  = (left_q >= n_held) || (left_q == 2'd0);

  // Phase update for one byte beat
  always_comb begin
    phase_d      = phase_q;
    win_d        = win_q;
    fill_d       = fill_q;
    held_d       = held_q;
    left_d       = left_q;
    params_d     = params_q;
    frame_push_o = 1'b0;
    frame_o      = '0;
    if (byte_valid_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (fill_q == 2'd3 && cand == sync_q) begin
            phase_d = PH_TYPE;
            win_d   = '0;
            fill_d  = '0;
          end else begin
            win_d = cand[23:0];
            if (fill_q != 2'd3) begin
              fill_d = fill_q + 2'd1;
            end
          end
        end
        PH_TYPE: begin
          held_d   = rx_byte_i;
          params_d = '0;
          if (n_type == 2'd0) begin
            frame_push_o     = 1'b1;
            frame_o.msg_type = rx_byte_i;
            phase_d          = PH_HUNT;
            left_d           = '0;
            win_d            = '0;
            fill_d           = '0;
          end else begin
            left_d  = n_type;
            phase_d = PH_PARAMS;
          end
        end
        PH_PARAMS: begin
          if (first) begin
            params_d[7:0] = rx_byte_i;
          end else begin
            params_d[15:8] = rx_byte_i;
          end
          if (left_q <= 2'd1 || n_held <= 2'd1) begin
            frame_push_o      = 1'b1;
            frame_o.msg_type  = held_q;
            frame_o.led_index = (n_held >= 2'd1) ? params_d[7:0] : 8'h00;
            frame_o.led_value = (n_held >= 2'd2) ? params_d[15:8] : 8'h00;
            phase_d           = PH_HUNT;
            left_d            = '0;
            win_d             = '0;
            fill_d            = '0;
          end else begin
            left_d = left_q - 2'd1;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          left_d  = '0;
          win_d   = '0;
          fill_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      sync_q   <= SYNC_WORD_RESET;
      win_q    <= '0;
      fill_q   <= '0;
      held_q   <= '0;
      left_q   <= '0;
      params_q <= '0;
    end else begin
      phase_q  <= phase_d;
      win_q    <= win_d;
      fill_q   <= fill_d;
      held_q   <= held_d;
      left_q   <= left_d;
      params_q <= params_d;
      if (cfg_we_i) begin
        sync_q <= cfg_data_i;
      end
    end
  end

endmodule

>>> design/sflc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sflc_back
// Command executor: runs one decoded frame per cycle while the result queue
// is not full against the LED bank and builds its reply.
// ----------------------------------------------------------------------------
module sflc_back
  import sflc_pkg::*;
#(
  parameter int NUM_LEDS = 3
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    frame_valid_i,
  input  frame_t  frame_i,
  output logic    frame_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  localparam int IdxW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  logic [NUM_LEDS-1:0] bank_q, bank_d;
  logic [7:0]          bank_ext;
  logic                in_range;
  logic [IdxW-1:0]     bit_sel;

  assign frame_pop_o = frame_valid_i && !res_full_i;
  assign res_push_o  = frame_pop_o;
  assign in_range    = (frame_i.led_index < 8'(NUM_LEDS));
  assign bit_sel     = frame_i.led_index[IdxW-1:0];
  assign bank_ext    = 8'(bank_d);

  // Execute the command and build the reply
  always_comb begin
    bank_d                = bank_q;
    res_o                 = '0;
    res_o.msg_type        = frame_i.msg_type;
    res_o.cmd_led_index   = frame_i.led_index;
    res_o.cmd_led_value   = frame_i.led_value;
    res_o.reply_type      = REPLY_UNKNOWN;
    if (frame_i.msg_type == TYPE_SET && in_range) begin
      bank_d[bit_sel]  = (frame_i.led_value != 8'h00);
      res_o.reply_type = REPLY_ACK;
    end else if (frame_i.msg_type == TYPE_GET && in_range) begin
      res_o.reply_type      = REPLY_STATUS;
      res_o.reply_led_index = frame_i.led_index;
      res_o.reply_led_state = bank_q[bit_sel];
    end
    res_o.led_outputs = bank_ext[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= '0;
    end else if (frame_pop_o) begin
      bank_q <= bank_d;
    end
  end

endmodule

>>> tb/sv/sync_frame_led_command_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_led_command_parser_tb
// Self-checking bench for the sync-framed LED command parser.
// ----------------------------------------------------------------------------
// A stimulus process queues received bytes: a few hand-picked frames, then
// phases of random frames, broken sync prefixes and line noise under several
// sync words and idle patterns. A clocked driver pushes the bytes and runs a
// cycle-free model of the parser on every accepted byte, which queues the
// replies that byte should produce. A clocked monitor pops result beats and
// compares them field by field against that queue. One phase holds off the
// result side for a long stretch so both internal queues fill and the input
// stalls.
// ----------------------------------------------------------------------------
module sync_frame_led_command_parser_tb;
  import sflc_pkg::*;

  localparam int          NUM_LEDS     = 3;
  localparam int          DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int          PHASE_BYTES  = 400;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_TYPE   = 2'd1,
    PH_PARAMS = 2'd2
  } rx_phase_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  rx_byte_i   = '0;
  logic        pop         = 1'b0;
  logic        empty;
  logic [7:0]  msg_type_o;
  logic [7:0]  cmd_led_index_o;
  logic [7:0]  cmd_led_value_o;
  logic [7:0]  reply_type_o;
  logic [7:0]  reply_led_index_o;
  logic        reply_led_state_o;
  logic [2:0]  led_outputs_o;

  // Bytes waiting to be pushed and replies waiting to be popped
  logic [7:0] rx_byte_q[$];
  result_t    reply_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_kick     = 1'b0;
  int unsigned hold_left;
  int unsigned err_count     = 0;

  // Parser model state
  logic [31:0] pred_sync;
  rx_phase_e   pred_phase;
  logic [23:0] pred_window;
  logic [1:0]  pred_fill;
  logic [7:0]  pred_type;
  logic [1:0]  pred_left;
  logic [15:0] pred_params;
  logic [7:0]  pred_leds;

  result_t drv_reply;
  result_t beat_got;
  result_t beat_want;

  sync_frame_led_command_parser #(
    .NUM_LEDS (NUM_LEDS)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .push              (push),
    .full              (full),
    .rx_byte_i         (rx_byte_i),
    .pop               (pop),
    .empty             (empty),
    .msg_type_o        (msg_type_o),
    .cmd_led_index_o   (cmd_led_index_o),
    .cmd_led_value_o   (cmd_led_value_o),
    .reply_type_o      (reply_type_o),
    .reply_led_index_o (reply_led_index_o),
    .reply_led_state_o (reply_led_state_o),
    .led_outputs_o     (led_outputs_o)
  );

  always #5 clk_i = ~clk_i;

  // Number of parameter bytes that follow a type byte
  function automatic int unsigned frame_param_count(input logic [7:0] t);
    if (t == TYPE_SET || t == TYPE_STATUS) return 2;
    if (t == TYPE_GET) return 1;
    return 0;
  endfunction

  // Run the held command against the LED bank and go back to hunting
  function automatic result_t close_frame();
    result_t     r;
    int unsigned n;
    logic [7:0]  idx;
    logic [7:0]  val;
    n   = frame_param_count(pred_type);
    idx = (n >= 1) ? pred_params[7:0] : 8'h00;
    val = (n >= 2) ? pred_params[15:8] : 8'h00;
    r   = '0;
    r.msg_type      = pred_type;
    r.cmd_led_index = idx;
    r.cmd_led_value = val;
    r.reply_type    = REPLY_UNKNOWN;
    if (pred_type == TYPE_SET) begin
      if (idx < NUM_LEDS) begin
        pred_leds[idx] = (val != 8'h00);
        r.reply_type   = REPLY_ACK;
      end
    end else if (pred_type == TYPE_GET) begin
      if (idx < NUM_LEDS) begin
        r.reply_type      = REPLY_STATUS;
        r.reply_led_index = idx;
        r.reply_led_state = pred_leds[idx];
      end
    end
    r.led_outputs = pred_leds[2:0];
    pred_phase  = PH_HUNT;
    pred_left   = '0;
    pred_window = '0;
    pred_fill   = '0;
    return r;
  endfunction

  // Advance the parser model by one byte; return 1 when a reply results
  function automatic bit parse_rx_byte(input logic [7:0] b, output result_t res);
    logic [31:0] cand;
    int unsigned n;
    bit          first;
    res = '0;
    case (pred_phase)
      PH_HUNT: begin
        cand = {pred_window, b};
        if (pred_fill == 2'd3 && cand == pred_sync) begin
          pred_phase  = PH_TYPE;
          pred_window = '0;
          pred_fill   = '0;
        end else begin
          pred_window = cand[23:0];
          if (pred_fill != 2'd3) pred_fill = pred_fill + 2'd1;
        end
        return 1'b0;
      end
      PH_TYPE: begin
        pred_type   = b;
        pred_params = '0;
        n = frame_param_count(b);
        if (n == 0) begin
          res = close_frame();
          return 1'b1;
        end
        pred_left  = n[1:0];
        pred_phase = PH_PARAMS;
        return 1'b0;
      end
      PH_PARAMS: begin
        n = frame_param_count(pred_type);
        first = (pred_left >= n) || (pred_left == 2'd0);
        if (first) pred_params[7:0] = b;
        else pred_params[15:8] = b;
        if (pred_left <= 2'd1 || n <= 1) begin
          res = close_frame();
          return 1'b1;
        end
        pred_left = pred_left - 2'd1;
        return 1'b0;
      end
      default: begin
        pred_phase  = PH_HUNT;
        pred_left   = '0;
        pred_window = '0;
        pred_fill   = '0;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Driver: predict on every accepted beat, then offer the next byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      rx_byte_i <= '0;
    end else begin
      if (push && !full) begin
        if (parse_rx_byte(rx_byte_i, drv_reply)) reply_q.push_back(drv_reply);
      end
      if (!(push && full)) begin
        if (rx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push      <= 1'b1;
          rx_byte_i <= rx_byte_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down on its own
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each popped beat with the oldest expected reply
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        beat_got.msg_type        = msg_type_o;
        beat_got.cmd_led_index   = cmd_led_index_o;
        beat_got.cmd_led_value   = cmd_led_value_o;
        beat_got.reply_type      = reply_type_o;
        beat_got.reply_led_index = reply_led_index_o;
        beat_got.reply_led_state = reply_led_state_o;
        beat_got.led_outputs     = led_outputs_o;
        if (reply_q.size() == 0) begin
          $display("%0t: result beat with none expected, expected none, actual %h",
                   $time, beat_got);
          err_count++;
        end else begin
          beat_want = reply_q.pop_front();
          check_field("msg_type", beat_want.msg_type, beat_got.msg_type);
          check_field("cmd_led_index", beat_want.cmd_led_index, beat_got.cmd_led_index);
          check_field("cmd_led_value", beat_want.cmd_led_value, beat_got.cmd_led_value);
          check_field("reply_type", beat_want.reply_type, beat_got.reply_type);
          check_field("reply_led_index", beat_want.reply_led_index,
                      beat_got.reply_led_index);
          check_field("reply_led_state", 8'(beat_want.reply_led_state),
                      8'(beat_got.reply_led_state));
          check_field("led_outputs", 8'(beat_want.led_outputs),
                      8'(beat_got.led_outputs));
        end
      end
      pop <= (hold_left == 0) && !hold_kick && ($urandom_range(99) >= stall_pct);
    end
  end

  // Write the sync word; only called while the parser is idle
  task automatic write_sync(input logic [31:0] word);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pred_sync = word;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned rx_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    stall_pct     = rx_pct;
  endtask

  // Wait until every byte went in and every reply came out, then drain
  task automatic wait_idle();
    while (rx_byte_q.size() != 0 || push || reply_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic queue_frame(input logic [7:0] t, input logic [7:0] idx,
                             input logic [7:0] val);
    int unsigned n;
    n = frame_param_count(t);
    for (int i = 3; i >= 0; i--) rx_byte_q.push_back(pred_sync[8*i +: 8]);
    rx_byte_q.push_back(t);
    if (n >= 1) rx_byte_q.push_back(idx);
    if (n >= 2) rx_byte_q.push_back(val);
  endtask

  task automatic queue_random_frame();
    logic [7:0] t;
    logic [7:0] idx;
    logic [7:0] val;
    case ($urandom_range(9))
      0, 1, 2: t = TYPE_SET;
      3, 4, 5: t = TYPE_GET;
      6:       t = TYPE_STATUS;
      7:       t = REPLY_ACK;
      8:       t = REPLY_UNKNOWN;
      default: t = 8'($urandom_range(255));
    endcase
    idx = ($urandom_range(4) != 0) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
    case ($urandom_range(2))
      0:       val = 8'h00;
      1:       val = 8'h01;
      default: val = 8'($urandom_range(255));
    endcase
    queue_frame(t, idx, val);
  endtask

  // Mostly well-formed frames; the rest noise and cut-off sync prefixes
  task automatic queue_random_bytes(input int count);
    int unsigned start;
    int unsigned k;
    start = rx_byte_q.size();
    while (rx_byte_q.size() - start < count) begin
      k = $urandom_range(99);
      if (k < 70) begin
        queue_random_frame();
      end else if (k < 85) begin
        for (int i = 3; i > 3 - int'($urandom_range(3, 1)); i--)
          rx_byte_q.push_back(pred_sync[8*i +: 8]);
      end else begin
        repeat ($urandom_range(6, 1)) rx_byte_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // Run limit
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    pred_sync   = SYNC_WORD_RESET;
    pred_phase  = PH_HUNT;
    pred_window = '0;
    pred_fill   = '0;
    pred_type   = '0;
    pred_left   = '0;
    pred_params = '0;
    pred_leds   = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset sync word
    @(negedge clk_i);
    queue_frame(TYPE_SET, 8'd2, 8'hFF);
    queue_frame(TYPE_GET, 8'd2, 8'h00);
    queue_frame(TYPE_SET, 8'hFF, 8'h80);
    queue_frame(TYPE_GET, 8'd3, 8'h00);
    queue_frame(TYPE_STATUS, 8'h00, 8'h00);
    queue_frame(REPLY_UNKNOWN, 8'h00, 8'h00);
    wait_idle();

    // Random phases: no idling, sender idle, receiver stall, both
    write_sync($urandom);
    set_idling(0, 0);
    @(negedge clk_i);
    queue_random_bytes(PHASE_BYTES);
    wait_idle();

    write_sync(32'h0000_0000);
    set_idling(63, 0);
    @(negedge clk_i);
    queue_random_bytes(PHASE_BYTES);
    wait_idle();

    write_sync(32'hFFFF_FFFF);
    set_idling(0, 63);
    @(negedge clk_i);
    queue_random_bytes(PHASE_BYTES);
    wait_idle();

    write_sync(SYNC_WORD_RESET);
    set_idling(35, 35);
    @(negedge clk_i);
    queue_random_bytes(PHASE_BYTES);
    wait_idle();

    // Back-pressure: hold the result side while frames keep arriving
    write_sync($urandom);
    set_idling(0, 0);
    hold_kick = 1'b1;
    @(negedge clk_i);
    hold_kick = 1'b0;
    repeat (20) queue_random_frame();
    wait_idle();

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
